### sv/assert_macros.svh
// Assertion helper macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### sv/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types and constants of the SHA-256 byte stream hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  // Start request to the compression core, and its status back.
  typedef struct packed {
    logic start;
  } core_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_MARK    = 8'h80;
  localparam logic [5:0] LAST_SINGLE = 6'd55;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

### sv/sha256_if.sv
// ----------------------------------------------------------------------------
// stream_if
// Valid/ready channels carrying one input word or one digest word.
// ----------------------------------------------------------------------------
interface in_stream_if (input logic clk);
  import sha256_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface out_stream_if (input logic clk);
  import sha256_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/sha256_core.sv
// ----------------------------------------------------------------------------
// sha256_core
// 64-round compression. Message words come from the 16-entry block memory,
// the schedule runs through a 16-word tap line, one round per cycle
// after the registered block read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sha256_core (
  input  logic                   clk,
  input  logic                   rst,
  input  sha256_pkg::core_req_t  req,
  input  logic [31:0]            chain_in [8],
  output logic [3:0]             blk_raddr,
  input  logic [31:0]            blk_rdata,
  output logic [31:0]            chain_out [8],
  output sha256_pkg::core_stat_t stat
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ROUND = 3'b010,
    S_ADD   = 3'b100
  } core_state_t;

  core_state_t state;
  logic [6:0]  rnd;       // address issued this cycle (0..63), 64 = drain
  logic        rd_valid;  // read data for round rnd_d is present
  logic [5:0]  rnd_d;
  logic [31:0] w2, w7, w15;
  logic [31:0] wv [8];
  logic [31:0] w_cur, w_new, t1, t2, s0, s1;
  logic [31:0] w_hist [16]; // taps of the last 16 schedule words

  // Round number gives read address for the message block.
  assign blk_raddr = rnd[3:0];

  // Schedule words for rounds >= 16 are taken from the tap line.
  always_comb begin
    w2  = w_hist[14];
    w15 = w_hist[1];
    w7  = w_hist[9];
    s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    w_new = s1 + w7 + s0 + w_hist[0];
    w_cur = (rnd_d < 6'd16) ? blk_rdata : w_new;
    t1 = wv[7] + (rotr(wv[4], 6) ^ rotr(wv[4], 11) ^ rotr(wv[4], 25)) +
         ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + ROUND_K[rnd_d] + w_cur;
    t2 = (rotr(wv[0], 2) ^ rotr(wv[0], 13) ^ rotr(wv[0], 22)) +
         ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
  end

  // Sequencer and round registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rnd      <= '0;
      rd_valid <= 1'b0;
      rnd_d    <= '0;
      stat     <= '0;
    end else begin
      stat.done <= (state == S_ADD);
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            state     <= S_ROUND;
            rnd       <= '0;
            rd_valid  <= 1'b0;
            stat.busy <= 1'b1;
            for (int i = 0; i < 8; i++) wv[i] <= chain_in[i];
          end
        end
        S_ROUND: begin
          if (rnd != 7'd64) rnd <= rnd + 7'd1;
          rd_valid <= (rnd != 7'd64);
          rnd_d    <= rnd[5:0];
          if (rd_valid) begin
            wv[7] <= wv[6];
            wv[6] <= wv[5];
            wv[5] <= wv[4];
            wv[4] <= wv[3] + t1;
            wv[3] <= wv[2];
            wv[2] <= wv[1];
            wv[1] <= wv[0];
            wv[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) w_hist[i] <= w_hist[i + 1];
            w_hist[15] <= w_cur;
            if (rnd_d == 6'd63) state <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) chain_out[i] <= chain_in[i] + wv[i];
          state     <= S_IDLE;
          stat.busy <= 1'b0;
          rd_valid  <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_start_idle, clk, rst, req.start, state == S_IDLE, "start while busy")
  `ASSERT_NEXT(a_done_pulse, clk, rst, stat.done, !stat.done, "done held two cycles")
  `ASSERT_IMPL(a_round_range, clk, rst, rd_valid && state == S_ROUND, rnd_d <= 6'd63,
               "round out of range")
endmodule

### sv/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream, digest emitted as eight 32-bit words.
// ----------------------------------------------------------------------------
// Usage: words arrive on in_ch (command, data_byte). Command append adds
// one message byte; command finish pads the message, runs the last one or
// two blocks and sends eight words on out_ch (word_index 0..7, last_word on
// index 7), then restarts for the next message.
// An append is taken while idle; the 64th byte of a block starts a
// compression (start, block reads and rounds, final add, hand-back), and
// no input is taken until it is done. A finish runs a pad sweep through
// the block memory and a compression, plus a second sweep and compression
// when more than 55 bytes are held, then one digest word per cycle while
// out_ch is ready. A stall on out_ch holds the current digest word; no
// input is taken until all eight words are delivered.
// Reset (rst, synchronous) restores the initial hash value, clears the
// byte count and length; block contents are undefined until written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sha256_byte_stream_hasher (
  input  logic         clk,
  input  logic         rst,
  in_stream_if.sink    in_ch,
  out_stream_if.source out_ch
);
  import sha256_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_COMP   = 7'b0000010,
    S_PADA   = 7'b0000100,
    S_COMPA  = 7'b0001000,
    S_PADB   = 7'b0010000,
    S_COMPB  = 7'b0100000,
    S_EMIT   = 7'b1000000
  } top_state_t;

  top_state_t  state;
  logic [31:0] blk [16];       // block memory, one 32-bit word per entry
  logic [31:0] blk_rdata;
  logic [3:0]  blk_raddr;
  logic [31:0] hold;           // word being assembled from bytes
  logic [5:0]  fill;
  logic [63:0] msg_bits;
  logic [63:0] total;
  logic [31:0] chain [8];
  logic [31:0] chain_new [8];
  logic [4:0]  pad_idx;
  logic        two_blocks;
  logic        started;
  logic [2:0]  widx;
  core_req_t   req;
  core_stat_t  cst;
  logic        wr_en;
  logic [3:0]  wr_addr;
  logic [31:0] wr_data;
  logic [31:0] pad_word;

  sha256_core u_core (
    .clk(clk), .rst(rst), .req(req), .chain_in(chain),
    .blk_raddr(blk_raddr), .blk_rdata(blk_rdata),
    .chain_out(chain_new), .stat(cst)
  );

  // Block memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) blk[wr_addr] <= wr_data;
    blk_rdata <= blk[blk_raddr];
  end

  // Padding word for index pad_idx. First pass builds marker/zero block,
  // the spill pass is zero; the length fills words 14, 15 of the last block.
  always_comb begin
    logic [31:0] mark;
    mark = '0;
    pad_word = '0;
    if (state == S_PADA) begin
      if (pad_idx[3:0] == fill[5:2]) begin
        unique case (fill[1:0])
          2'd0: mark = {PAD_MARK, 24'h0};
          2'd1: mark = {hold[31:24], PAD_MARK, 16'h0};
          2'd2: mark = {hold[31:16], PAD_MARK, 8'h0};
          default: mark = {hold[31:8], PAD_MARK};
        endcase
        pad_word = mark;
      end
    end
    if (!two_blocks || state == S_PADB) begin
      if (pad_idx[3:0] == 4'd14) pad_word = total[63:32];
      if (pad_idx[3:0] == 4'd15) pad_word = total[31:0];
    end
  end

  assign total = msg_bits + {55'h0, fill, 3'b000};

  // Write port select: append words or pad sweep.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill[5:2];
    wr_data = {hold[31:8], in_ch.data.data_byte};
    if (state == S_IDLE && in_ch.valid && in_ch.ready &&
        in_ch.data.command == CMD_APPEND && fill[1:0] == 2'd3) begin
      wr_en = 1'b1;
    end else if ((state == S_PADA || state == S_PADB) && !pad_idx[4] &&
                 (state == S_PADB || pad_idx[3:0] >= fill[5:2])) begin
      wr_en   = 1'b1;
      wr_addr = pad_idx[3:0];
      wr_data = pad_word;
    end
  end

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_EMIT);
  assign out_ch.data.digest_word = chain[widx];
  assign out_ch.data.word_index  = widx;
  assign out_ch.data.last_word   = (widx == 3'd7);
  assign req.start = (state == S_COMP || state == S_COMPA || state == S_COMPB) && !started;

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      msg_bits <= '0;
      started  <= 1'b0;
      widx     <= '0;
      pad_idx  <= '0;
      two_blocks <= 1'b0;
      for (int i = 0; i < 8; i++) chain[i] <= INIT_H[i];
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            if (in_ch.data.command == CMD_APPEND) begin
              unique case (fill[1:0])
                2'd0: hold[31:24] <= in_ch.data.data_byte;
                2'd1: hold[23:16] <= in_ch.data.data_byte;
                2'd2: hold[15:8]  <= in_ch.data.data_byte;
                default: hold     <= hold;
              endcase
              fill <= fill + 6'd1;
              if (fill == 6'd63) begin
                state <= S_COMP;
              end
            end else begin
              state      <= S_PADA;
              pad_idx    <= '0;
              two_blocks <= (fill > LAST_SINGLE);
            end
          end
        end
        S_COMP: begin
          started <= !cst.done;
          if (cst.done) begin
            for (int i = 0; i < 8; i++) chain[i] <= chain_new[i];
            msg_bits <= msg_bits + 64'd512;
            state    <= S_IDLE;
          end
        end
        S_PADA: begin
          pad_idx <= pad_idx + 5'd1;
          if (pad_idx == 5'd15) state <= S_COMPA;
        end
        S_COMPA: begin
          started <= !cst.done;
          if (cst.done) begin
            for (int i = 0; i < 8; i++) chain[i] <= chain_new[i];
            pad_idx <= '0;
            state   <= two_blocks ? S_PADB : S_EMIT;
            widx    <= '0;
          end
        end
        S_PADB: begin
          pad_idx <= pad_idx + 5'd1;
          if (pad_idx == 5'd15) state <= S_COMPB;
        end
        S_COMPB: begin
          started <= !cst.done;
          if (cst.done) begin
            for (int i = 0; i < 8; i++) chain[i] <= chain_new[i];
            widx    <= '0;
            state   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_ch.ready) begin
            widx <= widx + 3'd1;
            if (widx == 3'd7) begin
              for (int i = 0; i < 8; i++) chain[i] <= INIT_H[i];
              fill     <= '0;
              msg_bits <= '0;
              state    <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_no_in_while_out, clk, rst, out_ch.valid, !in_ch.ready,
               "input taken during digest output")
  `ASSERT_NEXT(a_full_block_runs, clk, rst,
               in_ch.valid && in_ch.ready && in_ch.data.command == CMD_APPEND &&
               fill == 6'd63, state == S_COMP, "full block not compressed")
  `ASSERT_IMPL(a_pad_idle_core, clk, rst, state == S_PADA || state == S_PADB, !cst.busy,
               "pad sweep while core busy")
endmodule

### bench/sha256_byte_stream_hasher_tb.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_tb
// Self-checking bench for the SHA-256 byte stream hasher. A table of directed
// messages, then spill lengths, a hold-off and random messages of mixed length.
// A software copy of the hash predicts the eight digest words of every finish;
// each output word is checked field by field against the oldest predicted word.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_tb;
  import sha256_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;

  in_stream_if  in_ch  (clk);
  out_stream_if out_ch (clk);

  sha256_byte_stream_hasher DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hash state of the predictor
  logic [31:0] hash_h [8];
  logic [7:0]  msg_block [64];
  int          msg_fill;
  logic [63:0] msg_bits;

  out_word_t   digest_queue [$];
  int          mismatch_count = 0;
  int          idle_cycles    = 0;
  bit          hold_off       = 1'b0;
  bit          stim_done      = 1'b0;

  // Directed table: command, byte, expected first digest word (0 = no check)
  typedef struct {
    logic        cmd;
    logic [7:0]  byte_val;
    logic [31:0] first_word;
  } dir_row_t;

  function automatic logic [31:0] rot_right(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One compression of msg_block into hash_h
  task automatic compress_msg_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rot_right(w[i-15], 7) ^ rot_right(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rot_right(w[i-2], 17) ^ rot_right(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = hash_h[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
      t2 = (rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] = hash_h[i] + v[i];
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hash_h[i] = INIT_H[i];
    msg_fill = 0;
    msg_bits = '0;
  endtask

  // Predict the effect of one accepted input word
  task automatic hash_word(in_word_t w);
    logic [63:0] total;
    out_word_t   o;
    if (w.command == CMD_APPEND) begin
      msg_block[msg_fill] = w.data_byte;
      msg_fill++;
      if (msg_fill == 64) begin
        compress_msg_block();
        msg_bits += 64'd512;
        msg_fill = 0;
      end
    end else begin
      total = msg_bits + 64'(msg_fill) * 64'd8;
      msg_block[msg_fill] = PAD_MARK;
      for (int i = msg_fill + 1; i < 64; i++) msg_block[i] = 8'h00;
      if (msg_fill > LAST_SINGLE) begin
        compress_msg_block();
        for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) msg_block[56+i] = total[63-8*i -: 8];
      compress_msg_block();
      for (int i = 0; i < 8; i++) begin
        o.digest_word = hash_h[i];
        o.word_index  = 3'(i);
        o.last_word   = (i == 7);
        digest_queue.push_back(o);
      end
      restart_hash();
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Offer one word and wait until it is taken; gaps come from the burst logic
  int burst_left = 0;
  task automatic send_word(logic cmd, logic [7:0] b);
    in_word_t w;
    int       gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 6)) : 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    w.command   = cmd;
    w.data_byte = b;
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    hash_word(w);
    burst_left--;
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) send_word(CMD_APPEND, 8'($urandom_range(0, 255)));
    send_word(CMD_FINISH, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (digest_queue.size() != 0) @(posedge clk);
  endtask

  // Receiver: pattern stalls, plus a long hold-off on request
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      out_ch.ready <= !hold_off && ((stall_phase % 11) < 7 || stall_phase[9]);
    end
  end

  // Output checker
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (digest_queue.size() == 0) begin
        report_mismatch("unexpected word", out_ch.data.digest_word, '0);
      end else begin
        want = digest_queue.pop_front();
        if (out_ch.data.digest_word !== want.digest_word)
          report_mismatch("digest_word", out_ch.data.digest_word, want.digest_word);
        if (out_ch.data.word_index !== want.word_index)
          report_mismatch("word_index", 32'(out_ch.data.word_index), 32'(want.word_index));
        if (out_ch.data.last_word !== want.last_word)
          report_mismatch("last_word", 32'(out_ch.data.last_word), 32'(want.last_word));
      end
    end
  end

  // Watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst || stim_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  dir_row_t dir_rows [$];

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    restart_hash();
    // Empty message, data byte ignored on finish
    dir_rows.push_back('{CMD_FINISH, 8'hff, 32'he3b0c442});
    // "abc"
    dir_rows.push_back('{CMD_APPEND, 8'h61, 32'h0});
    dir_rows.push_back('{CMD_APPEND, 8'h62, 32'h0});
    dir_rows.push_back('{CMD_APPEND, 8'h63, 32'h0});
    dir_rows.push_back('{CMD_FINISH, 8'h00, 32'hba7816bf});
    // Byte extremes
    dir_rows.push_back('{CMD_APPEND, 8'h00, 32'h0});
    dir_rows.push_back('{CMD_APPEND, 8'hff, 32'h0});
    dir_rows.push_back('{CMD_APPEND, 8'h80, 32'h0});
    dir_rows.push_back('{CMD_APPEND, 8'h7f, 32'h0});
    dir_rows.push_back('{CMD_FINISH, 8'h55, 32'h0});
    dir_rows.push_back('{CMD_APPEND, 8'haa, 32'h0});
    dir_rows.push_back('{CMD_FINISH, 8'h00, 32'h0});

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].first_word != 0) begin
        send_word(dir_rows[i].cmd, dir_rows[i].byte_val);
        if (digest_queue[0].digest_word !== dir_rows[i].first_word)
          report_mismatch("known digest", digest_queue[0].digest_word,
                          dir_rows[i].first_word);
      end else begin
        send_word(dir_rows[i].cmd, dir_rows[i].byte_val);
      end
    end
    wait_drained();

    // Tail lengths around the padding spill: 55, 56, 63, 64 bytes
    send_message(55);
    send_message(56);
    send_message(63);
    send_message(64);

    // Long receiver hold-off while the sender keeps offering
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        send_message(3);
        send_message(10);
      end
    join
    wait_drained();

    // Random messages, mostly short, a few near a full block
    for (int m = 0; m < 10; m++) begin
      case ($urandom_range(0, 9))
        0:       send_message($urandom_range(50, 70));
        default: send_message($urandom_range(0, 12));
      endcase
      if ($urandom_range(0, 7) == 0) wait_drained();
    end

    wait_drained();
    stim_done = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && digest_queue.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
